// File: hw/rtl/stereo_linear_resampler_defines.svh
// ----------------------------------------------------------------------------
// stereo_linear_resampler_defines
// assertion macros used by the resampler controller rtl
// ----------------------------------------------------------------------------
`ifndef STEREO_LINEAR_RESAMPLER_DEFINES_SVH
`define STEREO_LINEAR_RESAMPLER_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SLR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("resampler assertion failed");
// antecedent implies consequent in the next cycle
`define SLR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("resampler assertion failed");
`else
`define SLR_ASSERT_IMP(lbl, ante, cons)
`define SLR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg
// shared types, constants and helpers of the stereo linear resampler
// ----------------------------------------------------------------------------
`default_nettype none

package slr_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_W    = 16;
  localparam int STEP_W      = 24;
  localparam int DEPTH_W     = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  // position holds up to one + step - 1
  localparam int POS_W  = ((STEP_W > FRAC_BITS) ? STEP_W : FRAC_BITS) + 1;
  localparam int NPOS_W = POS_W + 1;
  localparam int PROD_W = SAMPLE_W + FRAC_BITS + 2;
  localparam int SUM_W  = PROD_W + 1;

  localparam logic [NPOS_W-1:0] ONE_POS = NPOS_W'(1) << FRAC_BITS;
  localparam logic [NPOS_W-1:0] TWO_POS = NPOS_W'(1) << (FRAC_BITS + 1);
  localparam logic [STEP_W-1:0] STEP_RESET = 24'h010000;
  localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_RESULTS);

  localparam logic [7:0] NIB_LO = 8'h0F;
  localparam logic [7:0] NIB_HI = 8'hF0;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_START = 2'd1,
    ST_SPAN  = 2'd2
  } slr_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP = 1'b0,
    CFG_DEPTH_MODE = 1'b1
  } slr_cfg_idx_t;

  typedef enum logic [DEPTH_W-1:0] {
    DEPTH_NIBBLE = 2'd0,
    DEPTH_BYTE   = 2'd1,
    DEPTH_WORD   = 2'd2
  } slr_depth_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture widened input frame
    logic cur_only;    // interpolate current against itself (tail span)
    logic issue;       // emit one output at the current position
    logic last_out;    // the issued output closes the request
    logic skip;        // advance position without output
    logic wrap;        // position minus one at end of the first span
    logic store_prev;  // current frame becomes previous
    logic clear;       // back to reset state
  } slr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic adv;         // output pipe can move
    logic pos_lt_one;  // position still inside the span
    logic nxt_ge_one;  // position after one step leaves the span
    logic nxt_ge_two;  // ... and also leaves the following span
  } slr_status_t;

  function automatic logic [SAMPLE_W-1:0] widen(input logic [SAMPLE_W-1:0] raw,
                                                input logic [DEPTH_W-1:0] mode);
    logic [7:0] b;
    b = raw[7:0];
    if (mode == DEPTH_NIBBLE) begin
      b = (b & NIB_LO) | ((b << 4) & NIB_HI);
      return {b, b};
    end else if (mode == DEPTH_BYTE) begin
      return {b, b};
    end else begin
      return raw;
    end
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/stereo_linear_resampler.sv
// ----------------------------------------------------------------------------
// stereo_linear_resampler
// stereo linear interpolation sample rate converter, controller plus datapath
// first output: an accepted request passes ST_START, then ST_SPAN issues it
//   into the product stage, which feeds the output register
// throughput: one output per cycle while spanning, unless out_stall holds a
//   full output register; in_stall stays high until a request is done; once
//   the 64 output cap of a request is reached, each remaining span walks
//   up to ceil(one / step) position steps without output
// reset: synchronous active low rst_n; config back to step 1.0 and 16 bit
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_linear_resampler (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration writes
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [slr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [slr_pkg::STEP_W-1:0]          cfg_data,
  // source frames
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic [slr_pkg::SAMPLE_W-1:0]        in_left_raw,
  input  wire logic [slr_pkg::SAMPLE_W-1:0]        in_right_raw,
  input  wire logic                                in_last_frame,
  // output frames
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic signed [slr_pkg::SAMPLE_W-1:0] out_left_out,
  output      logic signed [slr_pkg::SAMPLE_W-1:0] out_right_out,
  output      logic                                out_run_end
);

  slr_pkg::slr_cmd_t    cmd;
  slr_pkg::slr_status_t status;

  // the user must write config only while idle; the block does not enforce this, so writes are always taken
  assign cfg_ready = 1'b1;

  // controller: accepts one request at a time, walks the interpolation
  // positions of the span from the previous frame and, on the last frame,
  // the tail span that repeats the current frame
  slr_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_frame (in_last_frame),
    .in_stall      (in_stall),
    .status        (status),
    .cmd           (cmd)
  );

  // datapath: widening, position accumulator, two-stage blend pipe whose
  // output register decouples the result side from the controller
  slr_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_left_raw   (in_left_raw),
    .in_right_raw  (in_right_raw),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out),
    .out_run_end   (out_run_end)
  );

endmodule

`default_nettype wire

// File: hw/rtl/slr_datapath.sv
// ----------------------------------------------------------------------------
// slr_datapath
// config registers, frame and position registers, interpolation pipe
// ----------------------------------------------------------------------------
`default_nettype none

module slr_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  input  wire logic [slr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [slr_pkg::STEP_W-1:0]        cfg_data,
  input  wire logic [slr_pkg::SAMPLE_W-1:0]      in_left_raw,
  input  wire logic [slr_pkg::SAMPLE_W-1:0]      in_right_raw,
  input  wire slr_pkg::slr_cmd_t                 cmd,
  output      slr_pkg::slr_status_t              status,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic signed [slr_pkg::SAMPLE_W-1:0] out_left_out,
  output      logic signed [slr_pkg::SAMPLE_W-1:0] out_right_out,
  output      logic                              out_run_end
);

  localparam int SW = slr_pkg::SAMPLE_W;
  localparam int FB = slr_pkg::FRAC_BITS;
  localparam int PW = slr_pkg::POS_W;
  localparam int NW = slr_pkg::NPOS_W;
  localparam int MW = slr_pkg::PROD_W;
  localparam int AW = slr_pkg::SUM_W;
  localparam logic [AW-1:0] RND_BIAS = {{(AW-FB){1'b0}}, {FB{1'b1}}};

  // divide by one toward zero, keep low sample bits
  function automatic logic [SW-1:0] finish(input logic signed [SW-1:0] base,
                                           input logic signed [MW-1:0] prod);
    logic signed [AW-1:0] s;
    logic signed [AW-1:0] q;
    s = (AW'(base) <<< FB) + AW'(prod);
    if (s[AW-1]) begin
      s = s + $signed(RND_BIAS);
    end
    q = s >>> FB;
    return q[SW-1:0];
  endfunction

  logic [slr_pkg::STEP_W-1:0]  step_r;
  logic [slr_pkg::DEPTH_W-1:0] depth_r;
  logic [SW-1:0]               cur_l_r, cur_r_r, prev_l_r, prev_r_r;
  logic [PW-1:0]               pos_r;
  logic                        p_v_r, p_end_r;
  logic signed [SW-1:0]        p_base_l_r, p_base_r_r;
  logic signed [MW-1:0]        p_prod_l_r, p_prod_r_r;
  logic                        out_v_r, out_end_r;
  logic [SW-1:0]               out_l_r, out_r_r;

  logic [slr_pkg::STEP_W-1:0]  step_eff;
  logic [NW-1:0]               pos_sum;
  logic [SW-1:0]               a_l, a_r;
  logic signed [SW:0]          diff_l, diff_r;
  logic signed [FB:0]          frac_s;
  logic signed [MW-1:0]        prod_l_nxt, prod_r_nxt;
  logic                        adv;

  // zero step behaves as a step of one lsb
  assign step_eff = (step_r == '0) ? slr_pkg::STEP_W'(1) : step_r;
  assign pos_sum  = {1'b0, pos_r} + NW'(step_eff);
  assign adv      = !out_v_r || !out_stall;

  assign status.adv        = adv;
  assign status.pos_lt_one = {1'b0, pos_r} < slr_pkg::ONE_POS;
  assign status.nxt_ge_one = pos_sum >= slr_pkg::ONE_POS;
  assign status.nxt_ge_two = pos_sum >= slr_pkg::TWO_POS;

  assign a_l    = cmd.cur_only ? cur_l_r : prev_l_r;
  assign a_r    = cmd.cur_only ? cur_r_r : prev_r_r;
  assign diff_l = $signed({cur_l_r[SW-1], cur_l_r}) - $signed({a_l[SW-1], a_l});
  assign diff_r = $signed({cur_r_r[SW-1], cur_r_r}) - $signed({a_r[SW-1], a_r});
  assign frac_s = $signed({1'b0, pos_r[FB-1:0]});
  assign prod_l_nxt = diff_l * frac_s;
  assign prod_r_nxt = diff_r * frac_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= slr_pkg::STEP_RESET;
      depth_r <= slr_pkg::DEPTH_W'(slr_pkg::DEPTH_WORD);
    end else if (cfg_valid) begin
      if (cfg_index == slr_pkg::CFG_PHASE_STEP) begin
        step_r <= cfg_data;
      end else begin
        depth_r <= cfg_data[slr_pkg::DEPTH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      prev_l_r <= '0;
      prev_r_r <= '0;
    end else begin
      priority if (cmd.clear) begin
        pos_r <= '0;
      end else if (cmd.wrap) begin
        pos_r <= pos_r - slr_pkg::ONE_POS[PW-1:0];
      end else if (cmd.issue || cmd.skip) begin
        pos_r <= pos_sum[PW-1:0];
      end else begin
        pos_r <= pos_r;
      end
      if (cmd.clear) begin
        prev_l_r <= '0;
        prev_r_r <= '0;
      end else if (cmd.store_prev) begin
        prev_l_r <= cur_l_r;
        prev_r_r <= cur_r_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_l_r <= slr_pkg::widen(in_left_raw, depth_r);
      cur_r_r <= slr_pkg::widen(in_right_raw, depth_r);
    end
  end

  // stage one: products; stage two: output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      p_v_r   <= cmd.issue;
      out_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && cmd.issue) begin
      p_base_l_r <= $signed(a_l);
      p_base_r_r <= $signed(a_r);
      p_prod_l_r <= prod_l_nxt;
      p_prod_r_r <= prod_r_nxt;
      p_end_r    <= cmd.last_out;
    end
    if (adv && p_v_r) begin
      out_l_r   <= finish(p_base_l_r, p_prod_l_r);
      out_r_r   <= finish(p_base_r_r, p_prod_r_r);
      out_end_r <= p_end_r;
    end
  end

  assign out_valid     = out_v_r;
  assign out_left_out  = $signed(out_l_r);
  assign out_right_out = $signed(out_r_r);
  assign out_run_end   = out_end_r;

endmodule

`default_nettype wire

// File: hw/rtl/slr_ctrl.sv
// ----------------------------------------------------------------------------
// slr_ctrl
// sequencer for spans, output count and frame history
// ----------------------------------------------------------------------------
`default_nettype none
`include "stereo_linear_resampler_defines.svh"

module slr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_last_frame,
  output      logic                 in_stall,
  input  wire slr_pkg::slr_status_t status,
  output      slr_pkg::slr_cmd_t    cmd
);

  slr_pkg::slr_state_t         state_r, state_nxt;
  logic [slr_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        last_r, last_nxt;
  logic                        phase2_r, phase2_nxt;
  logic                        have_prev_r, have_prev_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slr_pkg::ST_IDLE;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      phase2_r    <= 1'b0;
      have_prev_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      phase2_r    <= phase2_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    phase2_nxt    = phase2_r;
    have_prev_nxt = have_prev_r;
    cmd           = '0;
    cmd.cur_only  = phase2_r;
    unique case (state_r)
      slr_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          last_nxt  = in_last_frame;
          state_nxt = slr_pkg::ST_START;
        end
      end
      slr_pkg::ST_START: begin
        priority if (have_prev_r) begin
          phase2_nxt = 1'b0;
          state_nxt  = slr_pkg::ST_SPAN;
        end else if (last_r) begin
          phase2_nxt = 1'b1;
          state_nxt  = slr_pkg::ST_SPAN;
        end else begin
          // first frame of a stream is only stored
          cmd.store_prev = 1'b1;
          have_prev_nxt  = 1'b1;
          state_nxt      = slr_pkg::ST_IDLE;
        end
      end
      slr_pkg::ST_SPAN: begin
        if (status.pos_lt_one) begin
          if (cnt_r < slr_pkg::MAX_CNT) begin
            if (status.adv) begin
              cmd.issue    = 1'b1;
              cnt_nxt      = cnt_r + slr_pkg::CNT_W'(1);
              cmd.last_out = (cnt_r == slr_pkg::MAX_CNT - slr_pkg::CNT_W'(1)) ||
                             (status.nxt_ge_one &&
                              (phase2_r || !last_r || status.nxt_ge_two));
            end
          end else begin
            // output cap reached, walk position past the span
            cmd.skip = 1'b1;
          end
        end else if (!phase2_r) begin
          cmd.wrap = 1'b1;
          if (last_r) begin
            phase2_nxt = 1'b1;
          end else begin
            cmd.store_prev = 1'b1;
            have_prev_nxt  = 1'b1;
            state_nxt      = slr_pkg::ST_IDLE;
          end
        end else begin
          cmd.clear     = 1'b1;
          have_prev_nxt = 1'b0;
          state_nxt     = slr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = slr_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != slr_pkg::ST_IDLE);

  `SLR_ASSERT_IMP(a_issue_cap, cmd.issue, cnt_r < slr_pkg::MAX_CNT)
  `SLR_ASSERT_NXT(a_accept_start, in_valid && !in_stall, state_r == slr_pkg::ST_START)
  `SLR_ASSERT_IMP(a_issue_span, cmd.issue, status.pos_lt_one && status.adv)

endmodule

`default_nettype wire
